@@ rtl/arp_table_aging_engine_core_assert.svh @@
// Assertion macros shared by the address resolution table engine.
`ifndef ARP_TABLE_AGING_ENGINE_CORE_ASSERT_SVH
`define ARP_TABLE_AGING_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk and held off while aresetn is low.
`define ATAE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and held off while aresetn is low.
`define ATAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/atae_pkg.sv @@
// Types and constants shared by the address resolution table engine.
package atae_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int AGE_W     = 16;
    localparam int KIND_W    = 2;
    localparam int IDX_OUT_W = 5;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 56;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    localparam logic [AGE_W-1:0] LIFETIME_RESET = 16'd300;

    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } entry_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic clear_wr;
        logic scan;
        logic commit;
        logic evict;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic addr_last;
        logic need_evict;
        logic out_busy;
    } sts_t;

endpackage

@@ rtl/atae_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module atae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/atae_ctrl.sv @@
// Sequencing state machine for the address resolution table engine.
module atae_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  atae_pkg::sts_t    sts,
    output atae_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_EVICT  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = sts.need_evict ? ST_EVICT : ST_DONE;
            end
            ST_EVICT: begin
                cmd.evict  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/atae_dp.sv @@
// Datapath of the address resolution table engine: entry memory, scan and result registers.
module atae_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  atae_pkg::cmd_t                     cmd,
    output atae_pkg::sts_t                     sts,
    input  logic [atae_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [atae_pkg::KIND_W-1:0]        s_tuser,
    input  logic                               cfg_wr_en,
    input  logic [atae_pkg::AGE_W-1:0]         cfg_wr_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [atae_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [0:0]                         m_tuser
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int EXT_W = AW + atae_pkg::IDX_OUT_W;
    localparam int EW    = $bits(atae_pkg::entry_t);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    logic [atae_pkg::AGE_W-1:0]  lifetime_reg;
    logic [AW-1:0]               addr_reg;
    logic [AW-1:0]               free_idx_reg;
    logic [AW-1:0]               victim_idx_reg;
    logic                        proc_valid_reg;
    logic [AW-1:0]               proc_idx_reg;

    logic [atae_pkg::KIND_W-1:0] kind_reg;
    logic [atae_pkg::IP_W-1:0]   ip_reg;
    logic [atae_pkg::MAC_W-1:0]  mac_reg;

    logic                        match_found_reg;
    logic [AW-1:0]               match_idx_reg;
    logic [atae_pkg::MAC_W-1:0]  match_mac_reg;
    logic                        inv_found_reg;
    logic [AW-1:0]               inv_idx_reg;

    logic                        res_hit_reg;
    logic [AW-1:0]               res_idx_reg;
    logic [atae_pkg::MAC_W-1:0]  res_mac_reg;

    logic                        m_tvalid_reg;
    logic                        out_hit_reg;
    logic [atae_pkg::IDX_OUT_W-1:0] out_idx_reg;
    logic [atae_pkg::MAC_W-1:0]  out_mac_reg;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    atae_pkg::entry_t            ram_wentry;
    logic [EW-1:0]               ram_rdata;
    atae_pkg::entry_t            rd_entry;
    atae_pkg::entry_t            aged_entry;
    logic                        is_add;
    logic [EXT_W-1:0]            idx_ext;

    assign rd_entry = atae_pkg::entry_t'(ram_rdata);
    assign is_add   = (kind_reg == atae_pkg::KIND_ADD);

    always_comb begin
        aged_entry     = rd_entry;
        aged_entry.age = rd_entry.age - 16'd1;
    end

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wentry = '0;
        if (cmd.clear_wr) begin
            ram_we = 1'b1;
        end else if (proc_valid_reg && kind_reg == atae_pkg::KIND_TICK && rd_entry.valid) begin
            ram_we     = 1'b1;
            ram_waddr  = proc_idx_reg;
            ram_wentry = (rd_entry.age == '0) ? '0 : aged_entry;
        end else if (cmd.commit && is_add) begin
            ram_we           = 1'b1;
            ram_waddr        = match_found_reg ? match_idx_reg : free_idx_reg;
            ram_wentry.valid = 1'b1;
            ram_wentry.ip    = ip_reg;
            ram_wentry.mac   = mac_reg;
            ram_wentry.age   = lifetime_reg;
        end else if (cmd.evict) begin
            ram_we    = 1'b1;
            ram_waddr = victim_idx_reg;
        end
    end

    atae_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lifetime_reg   <= atae_pkg::LIFETIME_RESET;
            addr_reg       <= '0;
            free_idx_reg   <= '0;
            victim_idx_reg <= '0;
            proc_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lifetime_reg <= cfg_wr_data;
            end
            if (cmd.clear_wr || cmd.scan) begin
                addr_reg <= (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
            end
            proc_valid_reg <= cmd.scan;
            if (cmd.commit && is_add && !match_found_reg && inv_found_reg) begin
                free_idx_reg <= inv_idx_reg;
            end
            if (cmd.evict) begin
                free_idx_reg   <= victim_idx_reg;
                victim_idx_reg <= (victim_idx_reg == LAST_IDX) ? '0 : victim_idx_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        proc_idx_reg <= addr_reg;
        if (cmd.load) begin
            kind_reg        <= s_tuser;
            ip_reg          <= s_tdata[atae_pkg::IP_W-1:0];
            mac_reg         <= s_tdata[atae_pkg::S_TDATA_W-1:atae_pkg::IP_W];
            match_found_reg <= 1'b0;
            inv_found_reg   <= 1'b0;
        end else if (proc_valid_reg) begin
            if (rd_entry.valid && rd_entry.ip == ip_reg && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= proc_idx_reg;
                match_mac_reg   <= rd_entry.mac;
            end
            if (!rd_entry.valid && proc_idx_reg != free_idx_reg && !inv_found_reg) begin
                inv_found_reg <= 1'b1;
                inv_idx_reg   <= proc_idx_reg;
            end
        end
        if (cmd.commit) begin
            res_hit_reg <= 1'b0;
            res_idx_reg <= '0;
            res_mac_reg <= '0;
            if (is_add) begin
                res_hit_reg <= match_found_reg;
                res_idx_reg <= match_found_reg ? match_idx_reg : free_idx_reg;
            end else if (kind_reg == atae_pkg::KIND_LOOKUP && match_found_reg) begin
                res_hit_reg <= 1'b1;
                res_idx_reg <= match_idx_reg;
                res_mac_reg <= match_mac_reg;
            end
        end
        if (cmd.out_load) begin
            out_hit_reg <= res_hit_reg;
            out_idx_reg <= idx_ext[atae_pkg::IDX_OUT_W-1:0];
            out_mac_reg <= res_mac_reg;
        end
    end

    assign idx_ext = EXT_W'(res_idx_reg);

    assign sts.addr_last  = (addr_reg == LAST_IDX);
    assign sts.need_evict = is_add && !match_found_reg && !inv_found_reg;
    assign sts.out_busy   = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {3'b000, out_mac_reg, out_idx_reg};

endmodule

@@ rtl/arp_table_aging_engine_core.sv @@
// Top level of the address resolution table engine with aging and round-robin replacement.
// After reset the block clears its entry memory in one pass and takes no request until
// that pass ends. Each request then reads every entry once through the single read port
// of the entry memory, then passes the drain and commit steps, and an eviction of the
// round-robin victim when an add finds the table full. One request is in work at a time;
// the finished result waits in an output register while the next request is taken.
`include "arp_table_aging_engine_core_assert.svh"

module arp_table_aging_engine_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ip_address [31:0], mac_address [79:32]
    input  logic [atae_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  logic [atae_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_index [4:0], found_mac [52:5], zero [55:53]
    output logic [atae_pkg::M_TDATA_W-1:0]  m_tdata,
    // hit [0]
    output logic [0:0]                      m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [atae_pkg::AGE_W-1:0]      cfg_wr_data
);

    atae_pkg::cmd_t cmd;
    atae_pkg::sts_t sts;

    atae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    atae_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    assign s_tready = cmd.in_ready;

    `ATAE_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken early")
    `ATAE_ASSERT_NOW(a_no_overwrite, cmd.out_load, !sts.out_busy, "pending result overwritten")
    `ATAE_ASSERT_NOW(a_evict_after_commit, cmd.evict, $past(cmd.commit), "eviction out of order")

endmodule
